@@ rtl/gpp_pkg.sv @@
// Shared types and constants for the gear position controller.
`default_nettype none

package gpp_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_GEAR   = 2'd1,
    KIND_MANUAL = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    GEAR_NEUTRAL = 2'd0,
    GEAR_FIRST   = 2'd1,
    GEAR_SECOND  = 2'd2,
    GEAR_MANUAL  = 2'd3
  } gear_t;

  typedef enum logic [2:0] {
    REG_FIRST_POS  = 3'd0,
    REG_SECOND_POS = 3'd1,
    REG_NEUTRAL    = 3'd2,
    REG_GAIN       = 3'd3,
    REG_TOLERANCE  = 3'd4
  } reg_idx_t;

  localparam int unsigned PosW  = 16;
  localparam int unsigned GainW = 8;
  localparam int unsigned TolW  = 15;
  localparam int unsigned ErrW  = PosW + 1;
  localparam int unsigned ProdW = ErrW + GainW + 1;
  localparam int unsigned DrvW  = 8;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 3;

  localparam logic [GainW-1:0] GAIN_RESET = 8'd179;
  localparam logic [TolW-1:0]  TOL_RESET  = 15'd50;
  localparam logic [DrvW-1:0]  DRIVE_MID  = 8'd128;
  localparam logic [DrvW-1:0]  DRIVE_MAX  = 8'd255;

endpackage

`default_nettype wire

@@ rtl/gear_position_p_controller.sv @@
// Gear-shift actuator proportional position loop, top level.
//
// Requests enter on the in_ channel (valid/stall): a gear request loads the
// target from that gear's position register, a manual target loads it
// directly, and a position sample produces one result on the out_ channel
// (drive duty, reached gear, in-position flag). Other requests give no result.
// Registers are written through cfg_wr_en / cfg_index / cfg_data; the user
// must do so only while idle, which the block does not enforce; writes to
// indexes past the tolerance register are dropped. Throughput: one request
// per cycle unless in_stall is high; a sample goes from the request register
// through the error, one 9x17 multiply and the clamp to the result register.
// When the receiver stalls, the held result stays on out_ and one more
// sample is taken into the request register; after that in_stall rises.
// Requests that give no result never wait on the output side.
// Synchronous reset clears both valid flags, loads the register defaults
// (gain 179, tolerance 50, positions 0) and sets target 0, gears neutral.
`default_nettype none

module gear_position_p_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire gpp_pkg::kind_t                in_kind,
  input  wire logic signed [15:0]            in_sample,
  input  wire logic [1:0]                    in_gear,
  input  wire logic signed [15:0]            in_target,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_drive,
  output logic [1:0]                         out_current_gear,
  output logic                               out_in_position,
  input  wire logic                          cfg_wr_en,
  input  wire logic [gpp_pkg::IdxW-1:0]      cfg_index,
  input  wire logic [gpp_pkg::CfgW-1:0]      cfg_data
);
  import gpp_pkg::*;

  // configuration
  logic signed [PosW-1:0] first_pos_r, second_pos_r, neutral_pos_r;
  logic [GainW-1:0]       gain_r;
  logic [TolW-1:0]        tol_r;

  // loop state
  logic signed [PosW-1:0] target_pos_r, target_pos_nxt;
  gear_t                  req_gear_r, req_gear_nxt;
  gear_t                  reached_gear_r, reached_gear_nxt;

  // request register
  logic                   s1_valid_r;
  kind_t                  s1_kind_r;
  logic signed [PosW-1:0] s1_sample_r;
  logic [1:0]             s1_gear_r;
  logic signed [PosW-1:0] s1_target_r;

  // result register
  logic                   out_valid_r;
  logic [DrvW-1:0]        out_drive_r, out_drive_nxt;
  gear_t                  out_gear_r;
  logic                   out_inpos_r, inpos_c;

  logic                   s1_is_sample, out_free, s1_adv, s1_fire_sample, in_acc;
  logic signed [ErrW-1:0] err_c;
  logic signed [ProdW-1:0] prod_c;
  logic signed [ProdW-9:0] quo_c;
  logic signed [ProdW-8:0] sum_c;
  logic [ErrW-1:0]        mag_c;

  assign s1_is_sample   = (s1_kind_r == KIND_SAMPLE);
  assign out_free       = !out_valid_r || !out_stall;
  assign s1_adv         = s1_valid_r && (!s1_is_sample || out_free);
  assign s1_fire_sample = s1_adv && s1_is_sample;
  assign in_stall       = s1_valid_r && !s1_adv;
  assign in_acc         = in_valid && !in_stall;

  // datapath: error, scaled drive, clamp, tolerance check
  always_comb begin
    err_c  = ErrW'(target_pos_r) - ErrW'(s1_sample_r);
    prod_c = $signed({1'b0, gain_r}) * ProdW'(err_c);
    quo_c  = prod_c[ProdW-1:8];  // arithmetic shift gives floor
    sum_c  = (ProdW-7)'(quo_c) + (ProdW-7)'($signed({1'b0, DRIVE_MID}));
    if (sum_c < 0) begin
      out_drive_nxt = '0;
    end else if (sum_c > (ProdW-7)'($signed({1'b0, DRIVE_MAX}))) begin
      out_drive_nxt = DRIVE_MAX;
    end else begin
      out_drive_nxt = sum_c[DrvW-1:0];
    end
    mag_c   = err_c[ErrW-1] ? ErrW'(-err_c) : ErrW'(err_c);
    inpos_c = (mag_c < {{(ErrW-TolW){1'b0}}, tol_r});
  end

  // state update for the request leaving the request register
  always_comb begin
    target_pos_nxt   = target_pos_r;
    req_gear_nxt     = req_gear_r;
    reached_gear_nxt = reached_gear_r;
    if (s1_adv) begin
      case (s1_kind_r)
        KIND_GEAR: begin
          case (s1_gear_r)
            GEAR_NEUTRAL: begin
              target_pos_nxt = neutral_pos_r;
              req_gear_nxt   = GEAR_NEUTRAL;
            end
            GEAR_FIRST: begin
              target_pos_nxt = first_pos_r;
              req_gear_nxt   = GEAR_FIRST;
            end
            GEAR_SECOND: begin
              target_pos_nxt = second_pos_r;
              req_gear_nxt   = GEAR_SECOND;
            end
            default: ;  // drop requests for the manual code
          endcase
        end
        KIND_MANUAL: begin
          target_pos_nxt = s1_target_r;
          req_gear_nxt   = GEAR_MANUAL;
        end
        KIND_SAMPLE: begin
          if (inpos_c) reached_gear_nxt = req_gear_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pos_r    <= '0;
      second_pos_r   <= '0;
      neutral_pos_r  <= '0;
      gain_r         <= GAIN_RESET;
      tol_r          <= TOL_RESET;
      target_pos_r   <= '0;
      req_gear_r     <= GEAR_NEUTRAL;
      reached_gear_r <= GEAR_NEUTRAL;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_FIRST_POS:  first_pos_r   <= cfg_data[PosW-1:0];
          REG_SECOND_POS: second_pos_r  <= cfg_data[PosW-1:0];
          REG_NEUTRAL:    neutral_pos_r <= cfg_data[PosW-1:0];
          REG_GAIN:       gain_r        <= cfg_data[GainW-1:0];
          REG_TOLERANCE:  tol_r         <= cfg_data[TolW-1:0];
          default: ;
        endcase
      end
      target_pos_r   <= target_pos_nxt;
      req_gear_r     <= req_gear_nxt;
      reached_gear_r <= reached_gear_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire_sample) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r   <= in_kind;
      s1_sample_r <= in_sample;
      s1_gear_r   <= in_gear;
      s1_target_r <= in_target;
    end
    if (s1_fire_sample) begin
      out_drive_r <= out_drive_nxt;
      out_gear_r  <= reached_gear_nxt;
      out_inpos_r <= inpos_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive        = out_drive_r;
  assign out_current_gear = out_gear_r;
  assign out_in_position  = out_inpos_r;

`ifndef SYNTHESIS
  a_stall_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with empty request register");

  a_gear_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_gear_r == reached_gear_r))
    else $error("reported gear differs from reached gear");

  a_zero_err_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire_sample && (err_c == '0)) |=> (out_drive_r == DRIVE_MID))
    else $error("zero error did not give mid drive");

  a_reach_gear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire_sample && inpos_c) |=> (reached_gear_r == $past(req_gear_r)))
    else $error("in-position sample did not take requested gear");

  a_manual_gear_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_kind_r == KIND_GEAR) && (s1_gear_r == GEAR_MANUAL))
      |=> ($stable(req_gear_r) && $stable(target_pos_r)))
    else $error("gear request with manual code changed the target");
`endif

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for gear_position_p_controller with a built-in loop predictor.
`timescale 1ns / 100ps

module tb_top;
  import gpp_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam logic signed [15:0] POS_MIN = 16'sh8000;
  localparam logic signed [15:0] POS_MAX = 16'sh7FFF;

  typedef struct packed {
    logic [7:0] drive;
    gear_t      gear;
    logic       in_pos;
  } loop_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  kind_t              in_kind = KIND_SAMPLE;
  logic signed [15:0] in_sample = '0;
  logic [1:0]         in_gear = '0;
  logic signed [15:0] in_target = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_drive;
  logic [1:0]         out_current_gear;
  logic               out_in_position;
  logic               cfg_wr_en = 1'b0;
  logic [IdxW-1:0]    cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  // Predictor state and register copies
  logic signed [15:0] pos_first;
  logic signed [15:0] pos_second;
  logic signed [15:0] pos_neutral;
  logic [7:0]         loop_gain;
  logic [14:0]        tol_limit;
  logic signed [15:0] target_pos;
  gear_t              gear_asked;
  gear_t              gear_held;

  loop_result_t pending_loop_results[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  gear_position_p_controller u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_sample        (in_sample),
    .in_gear          (in_gear),
    .in_target        (in_target),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_drive        (out_drive),
    .out_current_gear (out_current_gear),
    .out_in_position  (out_in_position),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void reset_loop_model();
    pos_first = '0;
    pos_second = '0;
    pos_neutral = '0;
    loop_gain = GAIN_RESET;
    tol_limit = TOL_RESET;
    target_pos = '0;
    gear_asked = GEAR_NEUTRAL;
    gear_held = GEAR_NEUTRAL;
  endfunction

  function automatic void model_register_write(input logic [IdxW-1:0] idx,
                                               input logic [CfgW-1:0] value);
    case (idx)
      REG_FIRST_POS:  pos_first = value;
      REG_SECOND_POS: pos_second = value;
      REG_NEUTRAL:    pos_neutral = value;
      REG_GAIN:       loop_gain = value[7:0];
      REG_TOLERANCE:  tol_limit = value[14:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_loop_step(input kind_t kind,
                                            input logic signed [15:0] smp,
                                            input logic [1:0] gr,
                                            input logic signed [15:0] tgt);
    logic signed [16:0] err;
    logic signed [31:0] prod;
    logic [16:0]        mag;
    int                 duty;
    loop_result_t       res;
    case (kind)
      KIND_GEAR: begin
        case (gr)
          GEAR_NEUTRAL: begin
            target_pos = pos_neutral;
            gear_asked = GEAR_NEUTRAL;
          end
          GEAR_FIRST: begin
            target_pos = pos_first;
            gear_asked = GEAR_FIRST;
          end
          GEAR_SECOND: begin
            target_pos = pos_second;
            gear_asked = GEAR_SECOND;
          end
          default: ;  // manual code in a gear request: drop it
        endcase
      end
      KIND_MANUAL: begin
        target_pos = tgt;
        gear_asked = GEAR_MANUAL;
      end
      KIND_SAMPLE: begin
        err = {target_pos[15], target_pos} - {smp[15], smp};
        prod = $signed({1'b0, loop_gain}) * err;
        // arithmetic shift gives the floor of the division by 256
        duty = int'(prod >>> 8) + int'(DRIVE_MID);
        if (duty > int'(DRIVE_MAX)) duty = int'(DRIVE_MAX);
        else if (duty < 0) duty = 0;
        mag = (err < 0) ? 17'(-err) : 17'(err);
        res.in_pos = (mag < 17'(tol_limit));
        if (res.in_pos) gear_held = gear_asked;
        res.drive = 8'(duty);
        res.gear = gear_held;
        pending_loop_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_loop_result();
    loop_result_t exp;
    if (pending_loop_results.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result: drive %0d gear %0d in_position %0b",
                 out_drive, out_current_gear, out_in_position);
      mismatches++;
    end else begin
      exp = pending_loop_results.pop_front();
      if (out_drive !== exp.drive || out_current_gear !== exp.gear ||
          out_in_position !== exp.in_pos) begin
        if (mismatches < 10)
          $display("mismatch (exp/act): drive %0d/%0d gear %0d/%0d in_position %0b/%0b",
                   exp.drive, out_drive, exp.gear, out_current_gear,
                   exp.in_pos, out_in_position);
        mismatches++;
      end
    end
  endfunction

  // Receiver: check each accepted result, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_loop_result();
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("gear_position_p_controller test failed");
    $finish;
  end

  // Hold the request until taken, predict it, then maybe idle a while
  task automatic send_request(input kind_t kind, input logic signed [15:0] smp,
                              input logic [1:0] gr, input logic signed [15:0] tgt);
    int gap;
    gap = 0;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sample <= smp;
    in_gear <= gr;
    in_target <= tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_loop_step(kind, smp, gr, tgt);
    while (gap < 16 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_loop_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    model_register_write(idx, value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int snd, input int rcv);
    idle_pct = snd;
    stall_pct = rcv;
  endtask

  function automatic logic signed [15:0] pick_position();
    case ($urandom_range(7))
      0:       return POS_MIN;
      1:       return POS_MAX;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly land around the tolerance band so both in_position values show up
  function automatic logic signed [15:0] pick_sample();
    int span;
    int v;
    case ($urandom_range(19)) inside
      [0:10]: begin
        span = int'(tol_limit) + int'(tol_limit) / 2 + 4;
        v = int'(target_pos) + int'($urandom_range(2 * span)) - span;
        if (v > int'(POS_MAX)) v = int'(POS_MAX);
        if (v < int'(POS_MIN)) v = int'(POS_MIN);
        return 16'(v);
      end
      18:      return POS_MIN;
      19:      return POS_MAX;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic randomize_settings();
    int pick;
    write_register(REG_FIRST_POS, pick_position());
    write_register(REG_SECOND_POS, pick_position());
    write_register(REG_NEUTRAL, pick_position());
    pick = $urandom_range(3);
    write_register(REG_GAIN, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd255 : 16'($urandom_range(255)));
    case ($urandom_range(4))
      0:       write_register(REG_TOLERANCE, 16'd0);
      1:       write_register(REG_TOLERANCE, 16'd32767);
      2:       write_register(REG_TOLERANCE, 16'($urandom_range(32767)));
      default: write_register(REG_TOLERANCE, 16'($urandom_range(2000)));
    endcase
  endtask

  task automatic run_random_items(input int count);
    int done;
    int pick;
    kind_t kind;
    logic [1:0] gr;
    logic signed [15:0] smp;
    logic signed [15:0] tgt;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      smp = 16'($urandom);
      tgt = 16'($urandom);
      gr = 2'($urandom);
      if (pick < 68) begin
        kind = KIND_SAMPLE;
        smp = pick_sample();
      end else if (pick < 82) begin
        kind = KIND_GEAR;
      end else if (pick < 94) begin
        kind = KIND_MANUAL;
        tgt = pick_position();
      end else begin
        kind = KIND_UNUSED;
      end
      send_request(kind, smp, gr, tgt);
      done++;
    end
  endtask

  task automatic test_reset_state();
    send_request(KIND_SAMPLE, 16'sd0, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_SAMPLE, 16'sd49, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_SAMPLE, -16'sd50, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_SAMPLE, POS_MAX, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_SAMPLE, POS_MIN, GEAR_NEUTRAL, 16'sd0);
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    write_register(REG_FIRST_POS, POS_MAX);
    write_register(REG_SECOND_POS, POS_MIN);
    write_register(REG_NEUTRAL, -16'sd1234);
    write_register(REG_GAIN, 16'd255);
    write_register(REG_TOLERANCE, 16'd32767);
    // indexes past the last register must leave everything alone
    for (int idx = int'(REG_TOLERANCE) + 1; idx < (1 << IdxW); idx++)
      write_register(IdxW'(idx), 16'h0000);
    send_request(KIND_GEAR, 16'sd0, GEAR_FIRST, 16'sd0);
    send_request(KIND_SAMPLE, POS_MIN, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_SAMPLE, 16'sd1, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_GEAR, 16'sd0, GEAR_SECOND, 16'sd0);
    send_request(KIND_SAMPLE, POS_MAX, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_GEAR, 16'sd0, GEAR_MANUAL, POS_MAX);
    send_request(KIND_SAMPLE, POS_MIN, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_UNUSED, POS_MAX, GEAR_FIRST, POS_MAX);
    send_request(KIND_SAMPLE, POS_MIN, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_MANUAL, 16'sd0, GEAR_NEUTRAL, 16'sd100);
    send_request(KIND_SAMPLE, 16'sd100, GEAR_NEUTRAL, 16'sd0);
    wait_for_results();
    // zero gain and zero tolerance: flat drive, never in position
    write_register(REG_GAIN, 16'd0);
    write_register(REG_TOLERANCE, 16'd0);
    send_request(KIND_SAMPLE, 16'sd100, GEAR_NEUTRAL, 16'sd0);
    send_request(KIND_GEAR, 16'sd0, GEAR_FIRST, 16'sd0);
    wait_for_results();
    // target must keep the position loaded by the last gear request
    write_register(REG_FIRST_POS, 16'h0000);
    write_register(REG_GAIN, 16'd128);
    write_register(REG_TOLERANCE, 16'd1);
    send_request(KIND_SAMPLE, POS_MAX, GEAR_NEUTRAL, 16'sd0);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    for (int mode = 0; mode < 4; mode++) begin
      for (int setting = 0; setting < 2; setting++) begin
        wait_for_results();
        randomize_settings();
        case (mode)
          0:       set_idling(0, 0);
          1:       set_idling(56, 0);
          2:       set_idling(0, 56);
          default: set_idling(21, 21);
        endcase
        run_random_items(220);
      end
    end
    wait_for_results();
  endtask

  // Long receiver hold while the sender keeps pushing: the block must fill and stall
  task automatic test_backpressure();
    randomize_settings();
    set_idling(0, 0);
    hold_request = HOLD_CYCLES;
    run_random_items(80);
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    randomize_settings();
    set_idling(21, 21);
    run_random_items(60);
    wait_for_results();
    run_random_items(60);
    wait_for_results();
  endtask

  initial begin
    reset_loop_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    test_sender_pause();
    if (mismatches == 0) begin
      $display("gear_position_p_controller test passed");
    end else begin
      $display("gear_position_p_controller test failed");
    end
    $finish;
  end

endmodule
